/* hdl/box_iou_unit_defines.svh */
// Assertion macros used by the checker file of the box IoU block.
`ifndef BOX_IOU_UNIT_DEFINES_SVH
`define BOX_IOU_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BXIOU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("box_iou_unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BXIOU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("box_iou_unit: next-cycle check failed");

`endif

/* hdl/bxiou_pkg.sv */
package bxiou_pkg;

   localparam int COORD_BITS_DEF    = 16;
   localparam int IOU_FRAC_BITS_DEF = 15;

   // Status that travels with each transaction down the pipeline.
   typedef struct packed {
      logic no_overlap;
      logic zero_union;
      logic full_cover;
   } flags_type;

endpackage

/* hdl/bxiou_overlap.sv */
module bxiou_overlap #(
   parameter int COORD_BITS = bxiou_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [COORD_BITS-1:0] box_x,
   input  logic [COORD_BITS-1:0] box_y,
   input  logic [COORD_BITS-1:0] box_w,
   input  logic [COORD_BITS-1:0] box_h,
   input  logic [COORD_BITS-1:0] truth_x,
   input  logic [COORD_BITS-1:0] truth_y,
   input  logic [COORD_BITS-1:0] truth_w,
   input  logic [COORD_BITS-1:0] truth_h,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [COORD_BITS:0]   out_ow,
   output logic [COORD_BITS:0]   out_oh,
   output logic [COORD_BITS-1:0] out_bw,
   output logic [COORD_BITS-1:0] out_bh,
   output logic [COORD_BITS-1:0] out_tw,
   output logic [COORD_BITS-1:0] out_th,
   output logic                  out_no_overlap
);

   // Edges at doubled scale need COORD_BITS+3 signed bits, their difference one more.
   localparam int EDGE_BITS = COORD_BITS + 4;

   function automatic logic signed [EDGE_BITS-1:0] span_overlap(
      input logic [COORD_BITS-1:0] c1,
      input logic [COORD_BITS-1:0] s1,
      input logic [COORD_BITS-1:0] c2,
      input logic [COORD_BITS-1:0] s2
   );
      logic signed [EDGE_BITS-1:0] l1, l2, r1, r2, lo, hi;
      l1 = $signed({3'b000, c1, 1'b0}) - $signed({4'b0000, s1});
      l2 = $signed({3'b000, c2, 1'b0}) - $signed({4'b0000, s2});
      r1 = $signed({3'b000, c1, 1'b0}) + $signed({4'b0000, s1});
      r2 = $signed({3'b000, c2, 1'b0}) + $signed({4'b0000, s2});
      lo = (l1 > l2) ? l1 : l2;
      hi = (r1 < r2) ? r1 : r2;
      return hi - lo;
   endfunction

   logic                        valid_ff;
   logic signed [EDGE_BITS-1:0] span_w, span_h;
   logic                        no_overlap_in, no_overlap_ff;
   logic [COORD_BITS:0]         ow_in, oh_in, ow_ff, oh_ff;
   logic [COORD_BITS-1:0]       bw_ff, bh_ff, tw_ff, th_ff;

   always_comb begin
      span_w        = span_overlap(box_x, box_w, truth_x, truth_w);
      span_h        = span_overlap(box_y, box_h, truth_y, truth_h);
      no_overlap_in = span_w[EDGE_BITS-1] | span_h[EDGE_BITS-1];
      // A positive overlap never exceeds twice a size, so COORD_BITS+1 bits hold it.
      // Zeroing both spans on no overlap makes the intersection product zero.
      ow_in = no_overlap_in ? '0 : span_w[COORD_BITS:0];
      oh_in = no_overlap_in ? '0 : span_h[COORD_BITS:0];
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         ow_ff         <= ow_in;
         oh_ff         <= oh_in;
         bw_ff         <= box_w;
         bh_ff         <= box_h;
         tw_ff         <= truth_w;
         th_ff         <= truth_h;
         no_overlap_ff <= no_overlap_in;
      end
   end

   assign out_valid      = valid_ff;
   assign out_ow         = ow_ff;
   assign out_oh         = oh_ff;
   assign out_bw         = bw_ff;
   assign out_bh         = bh_ff;
   assign out_tw         = tw_ff;
   assign out_th         = th_ff;
   assign out_no_overlap = no_overlap_ff;

endmodule

/* hdl/bxiou_area.sv */
module bxiou_area #(
   parameter int COORD_BITS = bxiou_pkg::COORD_BITS_DEF,
   parameter int UNI_BITS   = 2 * COORD_BITS + 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [COORD_BITS:0]   in_ow,
   input  logic [COORD_BITS:0]   in_oh,
   input  logic [COORD_BITS-1:0] in_bw,
   input  logic [COORD_BITS-1:0] in_bh,
   input  logic [COORD_BITS-1:0] in_tw,
   input  logic [COORD_BITS-1:0] in_th,
   input  logic                  in_no_overlap,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [UNI_BITS-1:0]   out_rem,
   output logic [UNI_BITS-1:0]   out_uni,
   output bxiou_pkg::flags_type  out_flags
);

   localparam int PROD_BITS  = 2 * COORD_BITS;
   localparam int INTER_BITS = 2 * COORD_BITS + 2;

   // Product stage.
   logic                  prod_valid_ff, prod_ready;
   logic [INTER_BITS-1:0] inter_ff;
   logic [PROD_BITS-1:0]  box_area_ff, truth_area_ff;
   logic                  prod_nov_ff;

   // Union stage.
   logic                  uni_valid_ff, uni_ready;
   logic [UNI_BITS-1:0]   uni_in, uni_ff, rem_ff;
   bxiou_pkg::flags_type  flags_in, flags_ff;

   assign prod_ready = !prod_valid_ff || uni_ready;
   assign uni_ready  = !uni_valid_ff || out_ready;
   assign in_ready   = prod_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         uni_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (uni_ready) begin
            uni_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready) begin
         inter_ff      <= INTER_BITS'(in_ow) * INTER_BITS'(in_oh);
         box_area_ff   <= PROD_BITS'(in_bw) * PROD_BITS'(in_bh);
         truth_area_ff <= PROD_BITS'(in_tw) * PROD_BITS'(in_th);
         prod_nov_ff   <= in_no_overlap;
      end
   end

   // Areas are taken at four times scale to match the doubled edges.
   always_comb begin
      uni_in = {1'b0, box_area_ff, 2'b00} + {1'b0, truth_area_ff, 2'b00}
               - {1'b0, inter_ff};
      flags_in.no_overlap = prod_nov_ff;
      flags_in.zero_union = (uni_in == '0);
      // The intersection never exceeds either area, so it reaches the union only
      // when both boxes coincide in area with it.
      flags_in.full_cover = ({1'b0, inter_ff} == uni_in);
   end

   always_ff @(posedge clock) begin
      if (uni_ready) begin
         uni_ff   <= uni_in;
         rem_ff   <= {1'b0, inter_ff};
         flags_ff <= flags_in;
      end
   end

   assign out_valid = uni_valid_ff;
   assign out_rem   = rem_ff;
   assign out_uni   = uni_ff;
   assign out_flags = flags_ff;

endmodule

/* hdl/bxiou_div_step.sv */
module bxiou_div_step #(
   parameter int UNI_BITS = 2 * bxiou_pkg::COORD_BITS_DEF + 3,
   parameter int QUO_BITS = bxiou_pkg::IOU_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [UNI_BITS-1:0]  in_rem,
   input  logic [UNI_BITS-1:0]  in_uni,
   input  logic [QUO_BITS-1:0]  in_quo,
   input  bxiou_pkg::flags_type in_flags,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [UNI_BITS-1:0]  out_rem,
   output logic [UNI_BITS-1:0]  out_uni,
   output logic [QUO_BITS-1:0]  out_quo,
   output bxiou_pkg::flags_type out_flags
);

   logic                 valid_ff;
   logic [UNI_BITS:0]    shifted;
   logic [UNI_BITS+1:0]  diff;
   logic                 take;
   logic [UNI_BITS-1:0]  rem_in, rem_ff, uni_ff;
   logic [QUO_BITS-1:0]  quo_in, quo_ff;
   bxiou_pkg::flags_type flags_ff;

   // One restoring step: the remainder stays below the union, so after the
   // shift a single subtract decides the quotient bit.
   always_comb begin
      shifted = {in_rem, 1'b0};
      diff    = {1'b0, shifted} - {2'b00, in_uni};
      take    = !diff[UNI_BITS+1];
      rem_in  = take ? diff[UNI_BITS-1:0] : shifted[UNI_BITS-1:0];
      quo_in  = {in_quo[QUO_BITS-2:0], take};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff   <= rem_in;
         uni_ff   <= in_uni;
         quo_ff   <= quo_in;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_uni   = uni_ff;
   assign out_quo   = quo_ff;
   assign out_flags = flags_ff;

endmodule

/* hdl/box_iou_unit.sv */
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   box_x/y/w/h, truth_x/y/w/h
// rsp       out        rsp_valid/rsp_ready   iou, no_overlap, zero_union
//
// One transaction per cycle sustained while rsp_ready is high; the stages in order are
// overlap, products, union, one restoring division step per quotient bit, and output.
// Every stage has its own valid bit and takes new data when it is empty or its
// successor moves, so bubbles close up during a stall and nothing is lost.
// Synchronous active-high reset empties all stages; payload registers are not reset.
module box_iou_unit #(
   parameter int COORD_BITS    = bxiou_pkg::COORD_BITS_DEF,
   parameter int IOU_FRAC_BITS = bxiou_pkg::IOU_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COORD_BITS-1:0]  req_box_x,
   input  logic [COORD_BITS-1:0]  req_box_y,
   input  logic [COORD_BITS-1:0]  req_box_w,
   input  logic [COORD_BITS-1:0]  req_box_h,
   input  logic [COORD_BITS-1:0]  req_truth_x,
   input  logic [COORD_BITS-1:0]  req_truth_y,
   input  logic [COORD_BITS-1:0]  req_truth_w,
   input  logic [COORD_BITS-1:0]  req_truth_h,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [IOU_FRAC_BITS:0] rsp_iou,
   output logic                   rsp_no_overlap,
   output logic                   rsp_zero_union
);

   localparam int UNI_BITS = 2 * COORD_BITS + 3;

   logic                  ov_valid, ov_ready;
   logic [COORD_BITS:0]   ov_ow, ov_oh;
   logic [COORD_BITS-1:0] ov_bw, ov_bh, ov_tw, ov_th;
   logic                  ov_no_overlap;

   logic                  stg_valid [IOU_FRAC_BITS+1];
   logic                  stg_ready [IOU_FRAC_BITS+1];
   logic [UNI_BITS-1:0]   stg_rem   [IOU_FRAC_BITS+1];
   logic [UNI_BITS-1:0]   stg_uni   [IOU_FRAC_BITS+1];
   logic [IOU_FRAC_BITS-1:0] stg_quo [IOU_FRAC_BITS+1];
   bxiou_pkg::flags_type  stg_flags [IOU_FRAC_BITS+1];

   logic                   rsp_valid_ff;
   logic [IOU_FRAC_BITS:0] iou_in, iou_ff;
   logic                   no_overlap_ff, zero_union_ff;

   bxiou_overlap #(
      .COORD_BITS(COORD_BITS)
   ) u_overlap (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .box_x         (req_box_x),
      .box_y         (req_box_y),
      .box_w         (req_box_w),
      .box_h         (req_box_h),
      .truth_x       (req_truth_x),
      .truth_y       (req_truth_y),
      .truth_w       (req_truth_w),
      .truth_h       (req_truth_h),
      .out_valid     (ov_valid),
      .out_ready     (ov_ready),
      .out_ow        (ov_ow),
      .out_oh        (ov_oh),
      .out_bw        (ov_bw),
      .out_bh        (ov_bh),
      .out_tw        (ov_tw),
      .out_th        (ov_th),
      .out_no_overlap(ov_no_overlap)
   );

   bxiou_area #(
      .COORD_BITS(COORD_BITS),
      .UNI_BITS  (UNI_BITS)
   ) u_area (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (ov_valid),
      .in_ready     (ov_ready),
      .in_ow        (ov_ow),
      .in_oh        (ov_oh),
      .in_bw        (ov_bw),
      .in_bh        (ov_bh),
      .in_tw        (ov_tw),
      .in_th        (ov_th),
      .in_no_overlap(ov_no_overlap),
      .out_valid    (stg_valid[0]),
      .out_ready    (stg_ready[0]),
      .out_rem      (stg_rem[0]),
      .out_uni      (stg_uni[0]),
      .out_flags    (stg_flags[0])
   );

   assign stg_quo[0] = '0;

   for (genvar k = 0; k < IOU_FRAC_BITS; k++) begin : g_div
      bxiou_div_step #(
         .UNI_BITS(UNI_BITS),
         .QUO_BITS(IOU_FRAC_BITS)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .in_valid (stg_valid[k]),
         .in_ready (stg_ready[k]),
         .in_rem   (stg_rem[k]),
         .in_uni   (stg_uni[k]),
         .in_quo   (stg_quo[k]),
         .in_flags (stg_flags[k]),
         .out_valid(stg_valid[k+1]),
         .out_ready(stg_ready[k+1]),
         .out_rem  (stg_rem[k+1]),
         .out_uni  (stg_uni[k+1]),
         .out_quo  (stg_quo[k+1]),
         .out_flags(stg_flags[k+1])
      );
   end

   // The final remainder is not needed once all quotient bits are out.
   logic [UNI_BITS-1:0] last_rem_unused;
   logic [UNI_BITS-1:0] last_uni_unused;
   assign last_rem_unused = stg_rem[IOU_FRAC_BITS];
   assign last_uni_unused = stg_uni[IOU_FRAC_BITS];

   always_comb begin
      if (stg_flags[IOU_FRAC_BITS].zero_union) begin
         iou_in = '0;
      end else if (stg_flags[IOU_FRAC_BITS].full_cover) begin
         iou_in = {1'b1, {IOU_FRAC_BITS{1'b0}}};
      end else begin
         iou_in = {1'b0, stg_quo[IOU_FRAC_BITS]};
      end
   end

   assign stg_ready[IOU_FRAC_BITS] = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stg_ready[IOU_FRAC_BITS]) begin
         rsp_valid_ff <= stg_valid[IOU_FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[IOU_FRAC_BITS]) begin
         iou_ff        <= iou_in;
         no_overlap_ff <= stg_flags[IOU_FRAC_BITS].no_overlap;
         zero_union_ff <= stg_flags[IOU_FRAC_BITS].zero_union;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_iou        = iou_ff;
   assign rsp_no_overlap = no_overlap_ff;
   assign rsp_zero_union = zero_union_ff;

endmodule

/* hdl/bxiou_checker.sv */
`include "box_iou_unit_defines.svh"

module bxiou_checker #(
   parameter int COORD_BITS    = bxiou_pkg::COORD_BITS_DEF,
   parameter int IOU_FRAC_BITS = bxiou_pkg::IOU_FRAC_BITS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [COORD_BITS-1:0]  req_box_w,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [IOU_FRAC_BITS:0] rsp_iou,
   input logic                   rsp_no_overlap,
   input logic                   rsp_zero_union
);

   localparam logic [IOU_FRAC_BITS:0] IOU_ONE = {1'b1, {IOU_FRAC_BITS{1'b0}}};

   // A ratio of areas can never pass 1.0.
   `BXIOU_ASSERT_SAME(a_iou_bounded, clock, reset, rsp_valid, rsp_iou <= IOU_ONE)

   // Disjoint boxes have an empty intersection, and so a zero ratio.
   `BXIOU_ASSERT_SAME(a_disjoint_zero, clock, reset, rsp_valid && rsp_no_overlap, rsp_iou == '0)

   // An empty union forces the ratio to zero.
   `BXIOU_ASSERT_SAME(a_empty_union_zero, clock, reset, rsp_valid && rsp_zero_union, rsp_iou == '0)

   // A stalled result holds its ratio until it is taken.
   `BXIOU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_iou))

   // A stalled request holds its box width until it is taken.
   `BXIOU_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_box_w))

endmodule

bind box_iou_unit bxiou_checker #(
   .COORD_BITS   (COORD_BITS),
   .IOU_FRAC_BITS(IOU_FRAC_BITS)
) u_bxiou_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_box_w     (req_box_w),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_iou       (rsp_iou),
   .rsp_no_overlap(rsp_no_overlap),
   .rsp_zero_union(rsp_zero_union)
);
